// ===== sv/two_region_memory_budget_unit_defines.svh =====
// Assertion macros for the two-region memory budget unit.
// Included by the top level; no other dependencies.
`ifndef TWO_REGION_MEMORY_BUDGET_UNIT_DEFINES_SVH
`define TWO_REGION_MEMORY_BUDGET_UNIT_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset
`define TRMB_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("trmb: invariant violated");

// Check that a condition in one cycle implies another in the next cycle
`define TRMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trmb: next-cycle check violated");

`endif

// ===== sv/trmb_pkg.sv =====
// Shared types, codes and constants of the two-region memory budget unit.
// No dependencies; used by the ALU, the sequencer and the top level.
`default_nettype none

package trmb_pkg;

   // Defaults for the top-level parameters
   localparam int ROLE_COUNT_DEF = 8;
   localparam int BYTE_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int REG_WIDTH  = 32;
   localparam int CMD_WIDTH  = 2;
   localparam int ROLE_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   // Packed word widths: role, internal_bytes, external_bytes padded to bytes
   localparam int REQ_TDATA_WIDTH = 72;
   // Seven 32-bit counters and holdings
   localparam int RSP_TDATA_WIDTH = 224;

   // Role codes with a fixed meaning
   localparam logic [ROLE_WIDTH-1:0] ROLE_NONE    = 3'd0;
   localparam logic [ROLE_WIDTH-1:0] ROLE_CONTROL = 3'd1;
   localparam logic [ROLE_WIDTH-1:0] ROLE_POOL    = 3'd2;
   localparam logic [ROLE_WIDTH-1:0] ROLE_RETIRED = 3'd3;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_RESERVE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_RETIRE  = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INTERNAL_LIMIT   = 2'd0,
      CSR_EXTERNAL_LIMIT   = 2'd1,
      CSR_CONTROL_HEADROOM = 2'd2
   } csr_index_type;

   // Operand sources of the shared add/subtract unit
   typedef enum logic [4:0] {
      OPND_LIM0,
      OPND_LIM1,
      OPND_USE0,
      OPND_USE1,
      OPND_AMT0,
      OPND_AMT1,
      OPND_HDRM,
      OPND_TMP,
      OPND_TMP2,
      OPND_PEAK0,
      OPND_PEAK1,
      OPND_HELD0_ROLE,
      OPND_HELD1_ROLE,
      OPND_HELD0_CTRL,
      OPND_HELD0_POOL,
      OPND_HELD1_POOL,
      OPND_HELD0_RET,
      OPND_HELD1_RET
   } opnd_type;

   // Write-back targets of the shared unit
   typedef enum logic [3:0] {
      DST_NONE,
      DST_TMP,
      DST_TMP2,
      DST_USE0,
      DST_USE1,
      DST_PEAK0,
      DST_PEAK1,
      DST_HELD0_ROLE,
      DST_HELD1_ROLE,
      DST_HELD0_POOL,
      DST_HELD1_POOL,
      DST_HELD0_RET,
      DST_HELD1_RET,
      DST_FAIL
   } dest_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_R_FREE0,
      ST_R_CHK0,
      ST_R_FREE1,
      ST_R_CHK1,
      ST_R_DATA,
      ST_R_ROOM,
      ST_R_ROOM2,
      ST_R_CHK2,
      ST_L_CHK0,
      ST_L_CHK1,
      ST_T_CHK0,
      ST_T_CHK1,
      ST_DECIDE,
      ST_A_USE0,
      ST_A_HELD0,
      ST_A_PEAK0,
      ST_A_USE1,
      ST_A_HELD1,
      ST_A_PEAK1,
      ST_L_USE0,
      ST_L_USE1,
      ST_L_HELD0,
      ST_L_HELD1,
      ST_T_POOL0,
      ST_T_RET0,
      ST_T_POOL1,
      ST_T_RET1,
      ST_REFUSE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Sequencer to datapath
   typedef struct packed {
      opnd_type a_sel;
      opnd_type b_sel;
      logic     sub;
      dest_type dst;
      logic     refuse;
      logic     clear;
      logic     rsp_load;
      logic     idle;
   } seq_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic    req_valid;
      cmd_type req_cmd;
      cmd_type cmd;
      logic    role_ctrl;
      logic    fail;
      logic    rsp_free;
   } seq_stat_type;

   // A role is usable when it is not "none" and has holding slots
   function automatic logic role_ok(logic [ROLE_WIDTH-1:0] r, int count);
      return (r != ROLE_NONE) && (int'(r) < count);
   endfunction

endpackage

`default_nettype wire

// ===== sv/two_region_memory_budget_unit.sv =====
// Top level of the two-region memory budget unit: accounting registers,
// operand selection, output register. Depends on trmb_pkg, trmb_alu, trmb_seq.
//
// Usage:
//   req channel: one command word per handshake (cmd in tuser; role and the
//   internal and external byte amounts in tdata). rsp channel: one result
//   word per command (ok flag in tuser; reject count, region totals, peaks
//   and the addressed role's holdings in tdata). csr port: write enable,
//   register index and data; write only while no command is in flight.
//   Reserve for a non-control role adds a headroom test that takes four ALU
//   passes. All arithmetic goes through one shared add/subtract unit, one pass
//   per cycle, so the command sequence length sets the rate; req_tready rises
//   again at the edge that raises rsp_tvalid. Reset clears all counters,
//   holdings and limits. If the receiver stalls, the result waits in the output
//   register while the next command is accepted and processed; that command
//   then holds before its own result is loaded.
`default_nettype none
`include "two_region_memory_budget_unit_defines.svh"

module two_region_memory_budget_unit #(
   parameter int ROLE_COUNT = trmb_pkg::ROLE_COUNT_DEF,
   parameter int BYTE_WIDTH = trmb_pkg::BYTE_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req_tdata: role[2:0], internal_bytes[34:3], external_bytes[66:35], zero pad
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [trmb_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // req_tuser: cmd[1:0]
   input  wire logic [trmb_pkg::CMD_WIDTH-1:0]        req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // rsp_tdata: reject_count, internal_in_use, external_in_use, internal_peak,
   // external_peak, role_internal_held, role_external_held (32 bits each)
   output logic [trmb_pkg::RSP_TDATA_WIDTH-1:0]       rsp_tdata,
   // rsp_tuser: ok
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [trmb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [trmb_pkg::REG_WIDTH-1:0]        csr_wdata
);

   localparam int RoleIdxW = $clog2(ROLE_COUNT);
   localparam logic [RoleIdxW-1:0] CtrlIdx = RoleIdxW'(trmb_pkg::ROLE_CONTROL);
   localparam logic [RoleIdxW-1:0] PoolIdx = RoleIdxW'(trmb_pkg::ROLE_POOL);
   localparam logic [RoleIdxW-1:0] RetIdx  = RoleIdxW'(trmb_pkg::ROLE_RETIRED);
   localparam int RW = trmb_pkg::REG_WIDTH;

   // Configuration registers
   logic [RW-1:0] int_limit_ff, ext_limit_ff, headroom_ff;

   // Latched command
   trmb_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [trmb_pkg::ROLE_WIDTH-1:0]   role_ff, role_in;
   logic [BYTE_WIDTH-1:0]             amt0_ff, amt0_in, amt1_ff, amt1_in;
   logic                              fail_ff, fail_in;
   logic [BYTE_WIDTH-1:0]             tmp_ff, tmp_in, tmp2_ff, tmp2_in;

   // Accounting state
   logic [BYTE_WIDTH-1:0] use0_ff, use0_in, use1_ff, use1_in;
   logic [BYTE_WIDTH-1:0] peak0_ff, peak0_in, peak1_ff, peak1_in;
   logic [BYTE_WIDTH-1:0] held0_ff [ROLE_COUNT];
   logic [BYTE_WIDTH-1:0] held0_in [ROLE_COUNT];
   logic [BYTE_WIDTH-1:0] held1_ff [ROLE_COUNT];
   logic [BYTE_WIDTH-1:0] held1_in [ROLE_COUNT];
   logic [RW-1:0]         refusals_ff, refusals_in;

   // Output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_ok_ff, rsp_ok_in;
   logic [trmb_pkg::RSP_TDATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   trmb_pkg::seq_ctrl_type ctrl;
   trmb_pkg::seq_stat_type stat;

   logic                  req_fire;
   logic                  role_valid;
   logic [RoleIdxW-1:0]   role_idx;
   logic [BYTE_WIDTH-1:0] held_role0, held_role1;
   logic [BYTE_WIDTH-1:0] lim0, lim1, hdrm;
   logic [BYTE_WIDTH-1:0] alu_a, alu_b, alu_res;
   logic                  alu_borrow;
   logic [trmb_pkg::ROLE_WIDTH-1:0] req_role;
   logic                  peaks_hold;

   assign req_tready = ctrl.idle;
   assign req_fire   = req_tvalid & ctrl.idle;
   assign req_role   = req_tdata[2:0];

   assign role_valid = trmb_pkg::role_ok(role_ff, ROLE_COUNT);
   assign role_idx   = RoleIdxW'(role_ff);
   assign held_role0 = role_valid ? held0_ff[role_idx] : '0;
   assign held_role1 = role_valid ? held1_ff[role_idx] : '0;

   assign lim0 = BYTE_WIDTH'(int_limit_ff);
   assign lim1 = BYTE_WIDTH'(ext_limit_ff);
   assign hdrm = BYTE_WIDTH'(headroom_ff);

   // Status to the sequencer
   assign stat.req_valid = req_tvalid;
   assign stat.req_cmd   = trmb_pkg::cmd_type'(req_tuser);
   assign stat.cmd       = cmd_ff;
   assign stat.role_ctrl = (role_ff == trmb_pkg::ROLE_CONTROL);
   assign stat.fail      = fail_ff;
   assign stat.rsp_free  = ~rsp_valid_ff | rsp_tready;

   trmb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // Operand A select
   always_comb begin
      unique case (ctrl.a_sel)
         trmb_pkg::OPND_LIM0:       alu_a = lim0;
         trmb_pkg::OPND_LIM1:       alu_a = lim1;
         trmb_pkg::OPND_USE0:       alu_a = use0_ff;
         trmb_pkg::OPND_USE1:       alu_a = use1_ff;
         trmb_pkg::OPND_AMT0:       alu_a = amt0_ff;
         trmb_pkg::OPND_AMT1:       alu_a = amt1_ff;
         trmb_pkg::OPND_HDRM:       alu_a = hdrm;
         trmb_pkg::OPND_TMP:        alu_a = tmp_ff;
         trmb_pkg::OPND_TMP2:       alu_a = tmp2_ff;
         trmb_pkg::OPND_PEAK0:      alu_a = peak0_ff;
         trmb_pkg::OPND_PEAK1:      alu_a = peak1_ff;
         trmb_pkg::OPND_HELD0_ROLE: alu_a = held_role0;
         trmb_pkg::OPND_HELD1_ROLE: alu_a = held_role1;
         trmb_pkg::OPND_HELD0_CTRL: alu_a = held0_ff[CtrlIdx];
         trmb_pkg::OPND_HELD0_POOL: alu_a = held0_ff[PoolIdx];
         trmb_pkg::OPND_HELD1_POOL: alu_a = held1_ff[PoolIdx];
         trmb_pkg::OPND_HELD0_RET:  alu_a = held0_ff[RetIdx];
         trmb_pkg::OPND_HELD1_RET:  alu_a = held1_ff[RetIdx];
         default:                   alu_a = '0;
      endcase
   end

   // Operand B select
   always_comb begin
      unique case (ctrl.b_sel)
         trmb_pkg::OPND_LIM0:       alu_b = lim0;
         trmb_pkg::OPND_LIM1:       alu_b = lim1;
         trmb_pkg::OPND_USE0:       alu_b = use0_ff;
         trmb_pkg::OPND_USE1:       alu_b = use1_ff;
         trmb_pkg::OPND_AMT0:       alu_b = amt0_ff;
         trmb_pkg::OPND_AMT1:       alu_b = amt1_ff;
         trmb_pkg::OPND_HDRM:       alu_b = hdrm;
         trmb_pkg::OPND_TMP:        alu_b = tmp_ff;
         trmb_pkg::OPND_TMP2:       alu_b = tmp2_ff;
         trmb_pkg::OPND_PEAK0:      alu_b = peak0_ff;
         trmb_pkg::OPND_PEAK1:      alu_b = peak1_ff;
         trmb_pkg::OPND_HELD0_ROLE: alu_b = held_role0;
         trmb_pkg::OPND_HELD1_ROLE: alu_b = held_role1;
         trmb_pkg::OPND_HELD0_CTRL: alu_b = held0_ff[CtrlIdx];
         trmb_pkg::OPND_HELD0_POOL: alu_b = held0_ff[PoolIdx];
         trmb_pkg::OPND_HELD1_POOL: alu_b = held1_ff[PoolIdx];
         trmb_pkg::OPND_HELD0_RET:  alu_b = held0_ff[RetIdx];
         trmb_pkg::OPND_HELD1_RET:  alu_b = held1_ff[RetIdx];
         default:                   alu_b = '0;
      endcase
   end

   trmb_alu #(
      .BYTE_WIDTH (BYTE_WIDTH)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (ctrl.sub),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   // Next state of the datapath registers
   always_comb begin
      cmd_in      = cmd_ff;
      role_in     = role_ff;
      amt0_in     = amt0_ff;
      amt1_in     = amt1_ff;
      fail_in     = fail_ff;
      tmp_in      = tmp_ff;
      tmp2_in     = tmp2_ff;
      use0_in     = use0_ff;
      use1_in     = use1_ff;
      peak0_in    = peak0_ff;
      peak1_in    = peak1_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      refusals_in = refusals_ff;

      // Latch a new command word; an unusable role fails reserve and release
      if (req_fire) begin
         cmd_in  = trmb_pkg::cmd_type'(req_tuser);
         role_in = req_role;
         amt0_in = BYTE_WIDTH'(req_tdata[34:3]);
         amt1_in = BYTE_WIDTH'(req_tdata[66:35]);
         fail_in = ((trmb_pkg::cmd_type'(req_tuser) == trmb_pkg::CMD_RESERVE) ||
                    (trmb_pkg::cmd_type'(req_tuser) == trmb_pkg::CMD_RELEASE)) &&
                   !trmb_pkg::role_ok(req_role, ROLE_COUNT);
      end

      // Write back the shared unit's result
      unique case (ctrl.dst)
         trmb_pkg::DST_NONE:       ;
         trmb_pkg::DST_TMP:        tmp_in  = alu_res;
         trmb_pkg::DST_TMP2:       tmp2_in = alu_res;
         trmb_pkg::DST_USE0:       use0_in = alu_res;
         trmb_pkg::DST_USE1:       use1_in = alu_res;
         trmb_pkg::DST_PEAK0:      if (alu_borrow) peak0_in = use0_ff;
         trmb_pkg::DST_PEAK1:      if (alu_borrow) peak1_in = use1_ff;
         trmb_pkg::DST_HELD0_ROLE: held0_in[role_idx] = alu_res;
         trmb_pkg::DST_HELD1_ROLE: held1_in[role_idx] = alu_res;
         trmb_pkg::DST_HELD0_POOL: held0_in[PoolIdx] = alu_res;
         trmb_pkg::DST_HELD1_POOL: held1_in[PoolIdx] = alu_res;
         trmb_pkg::DST_HELD0_RET:  held0_in[RetIdx] = alu_res;
         trmb_pkg::DST_HELD1_RET:  held1_in[RetIdx] = alu_res;
         trmb_pkg::DST_FAIL:       if (alu_borrow) fail_in = 1'b1;
         default:                  ;
      endcase

      // Count a refused reserve, saturating
      if (ctrl.refuse && (refusals_ff != '1)) begin
         refusals_in = refusals_ff + RW'(1);
      end

      // Clear counters: zero rejects, reset peaks to current use
      if (ctrl.clear) begin
         refusals_in = '0;
         peak0_in    = use0_ff;
         peak1_in    = use1_ff;
      end
   end

   // Output register next state
   always_comb begin
      rsp_ok_in   = rsp_ok_ff;
      rsp_data_in = rsp_data_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (ctrl.rsp_load) begin
         rsp_ok_in   = (cmd_ff == trmb_pkg::CMD_CLEAR) | ~fail_ff;
         rsp_data_in = {RW'(held_role1), RW'(held_role0),
                        RW'(peak1_ff), RW'(peak0_ff),
                        RW'(use1_ff), RW'(use0_ff), refusals_ff};
      end
   end

   // Control and accounting registers
   always_ff @(posedge clock) begin
      if (reset) begin
         int_limit_ff <= '0;
         ext_limit_ff <= '0;
         headroom_ff  <= '0;
         use0_ff      <= '0;
         use1_ff      <= '0;
         peak0_ff     <= '0;
         peak1_ff     <= '0;
         refusals_ff  <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROLE_COUNT; i++) begin
            held0_ff[i] <= '0;
            held1_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (trmb_pkg::csr_index_type'(csr_index))
               trmb_pkg::CSR_INTERNAL_LIMIT:   int_limit_ff <= csr_wdata;
               trmb_pkg::CSR_EXTERNAL_LIMIT:   ext_limit_ff <= csr_wdata;
               trmb_pkg::CSR_CONTROL_HEADROOM: headroom_ff  <= csr_wdata;
               default: ;
            endcase
         end
         use0_ff      <= use0_in;
         use1_ff      <= use1_in;
         peak0_ff     <= peak0_in;
         peak1_ff     <= peak1_in;
         refusals_ff  <= refusals_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      role_ff     <= role_in;
      amt0_ff     <= amt0_in;
      amt1_ff     <= amt1_in;
      tmp_ff      <= tmp_in;
      tmp2_ff     <= tmp2_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   assign peaks_hold = (peak0_ff >= use0_ff) && (peak1_ff >= use1_ff);

   // Between commands the high-water marks cover the current use
   `TRMB_ASSERT_ALWAYS(a_peak_covers_use, clock, reset, !ctrl.idle || peaks_hold)
   // The "none" role never holds bytes
   `TRMB_ASSERT_ALWAYS(a_none_role_empty, clock, reset, (held0_ff[0] == '0) && (held1_ff[0] == '0))
   // The reject counter only falls on a clear
   `TRMB_ASSERT_NEXT(a_refusals_monotonic, clock, reset, !ctrl.clear, refusals_ff >= $past(refusals_ff))
   // The sequencer leaves idle once a command word is taken
   `TRMB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !ctrl.idle)

endmodule

`default_nettype wire

// ===== sv/trmb_alu.sv =====
// Shared add/subtract unit of the memory budget unit.
// Subtract saturates at zero and flags a borrow; add wraps at the width.
`default_nettype none

module trmb_alu #(
   parameter int BYTE_WIDTH = trmb_pkg::BYTE_WIDTH_DEF
) (
   input  wire logic [BYTE_WIDTH-1:0] a,
   input  wire logic [BYTE_WIDTH-1:0] b,
   input  wire logic                  sub,
   output logic      [BYTE_WIDTH-1:0] res,
   output logic                      borrow
);

   logic [BYTE_WIDTH:0]   diff;
   logic [BYTE_WIDTH-1:0] sum;

   // One wide subtract and one wide add
   assign diff = {1'b0, a} - {1'b0, b};
   assign sum  = a + b;

   assign borrow = sub & diff[BYTE_WIDTH];

   always_comb begin
      if (sub) begin
         res = diff[BYTE_WIDTH] ? '0 : diff[BYTE_WIDTH-1:0];
      end else begin
         res = sum;
      end
   end

endmodule

`default_nettype wire

// ===== sv/trmb_seq.sv =====
// Command sequencer of the memory budget unit: steps the shared ALU through
// the checks and updates of each command. Depends on trmb_pkg.
`default_nettype none

module trmb_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trmb_pkg::seq_stat_type stat,
   output trmb_pkg::seq_ctrl_type     ctrl
);

   trmb_pkg::state_type state_ff;
   trmb_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trmb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and ALU control
   always_comb begin
      state_in      = state_ff;
      ctrl.a_sel    = trmb_pkg::OPND_LIM0;
      ctrl.b_sel    = trmb_pkg::OPND_USE0;
      ctrl.sub      = 1'b1;
      ctrl.dst      = trmb_pkg::DST_NONE;
      ctrl.refuse   = 1'b0;
      ctrl.clear    = 1'b0;
      ctrl.rsp_load = 1'b0;
      ctrl.idle     = 1'b0;

      unique case (state_ff)
         trmb_pkg::ST_IDLE: begin
            ctrl.idle = 1'b1;
            if (stat.req_valid) begin
               unique case (stat.req_cmd)
                  trmb_pkg::CMD_RESERVE: state_in = trmb_pkg::ST_R_FREE0;
                  trmb_pkg::CMD_RELEASE: state_in = trmb_pkg::ST_L_CHK0;
                  trmb_pkg::CMD_RETIRE:  state_in = trmb_pkg::ST_T_CHK0;
                  trmb_pkg::CMD_CLEAR:   state_in = trmb_pkg::ST_CLEAR;
               endcase
            end
         end

         // Reserve: free space of each region against the amount
         trmb_pkg::ST_R_FREE0: begin
            ctrl.a_sel = trmb_pkg::OPND_LIM0;
            ctrl.b_sel = trmb_pkg::OPND_USE0;
            ctrl.dst   = trmb_pkg::DST_TMP;
            state_in   = trmb_pkg::ST_R_CHK0;
         end
         trmb_pkg::ST_R_CHK0: begin
            ctrl.a_sel = trmb_pkg::OPND_TMP;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_R_FREE1;
         end
         trmb_pkg::ST_R_FREE1: begin
            ctrl.a_sel = trmb_pkg::OPND_LIM1;
            ctrl.b_sel = trmb_pkg::OPND_USE1;
            ctrl.dst   = trmb_pkg::DST_TMP;
            state_in   = trmb_pkg::ST_R_CHK1;
         end
         trmb_pkg::ST_R_CHK1: begin
            ctrl.a_sel = trmb_pkg::OPND_TMP;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = stat.role_ctrl ? trmb_pkg::ST_DECIDE : trmb_pkg::ST_R_DATA;
         end

         // Reserve, non-control roles: keep the control headroom clear
         trmb_pkg::ST_R_DATA: begin
            ctrl.a_sel = trmb_pkg::OPND_USE0;
            ctrl.b_sel = trmb_pkg::OPND_HELD0_CTRL;
            ctrl.dst   = trmb_pkg::DST_TMP;
            state_in   = trmb_pkg::ST_R_ROOM;
         end
         trmb_pkg::ST_R_ROOM: begin
            ctrl.a_sel = trmb_pkg::OPND_LIM0;
            ctrl.b_sel = trmb_pkg::OPND_HDRM;
            ctrl.dst   = trmb_pkg::DST_TMP2;
            state_in   = trmb_pkg::ST_R_ROOM2;
         end
         trmb_pkg::ST_R_ROOM2: begin
            ctrl.a_sel = trmb_pkg::OPND_TMP2;
            ctrl.b_sel = trmb_pkg::OPND_TMP;
            ctrl.dst   = trmb_pkg::DST_TMP;
            state_in   = trmb_pkg::ST_R_CHK2;
         end
         trmb_pkg::ST_R_CHK2: begin
            ctrl.a_sel = trmb_pkg::OPND_TMP;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_DECIDE;
         end

         // Release: the role must hold both amounts
         trmb_pkg::ST_L_CHK0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_L_CHK1;
         end
         trmb_pkg::ST_L_CHK1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_DECIDE;
         end

         // Retire: the pool must hold both amounts
         trmb_pkg::ST_T_CHK0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_POOL;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_T_CHK1;
         end
         trmb_pkg::ST_T_CHK1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_POOL;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_FAIL;
            state_in   = trmb_pkg::ST_DECIDE;
         end

         // Branch to the update sequence or drop the command
         trmb_pkg::ST_DECIDE: begin
            if (stat.fail) begin
               state_in = (stat.cmd == trmb_pkg::CMD_RESERVE) ?
                          trmb_pkg::ST_REFUSE : trmb_pkg::ST_DONE;
            end else begin
               unique case (stat.cmd)
                  trmb_pkg::CMD_RESERVE: state_in = trmb_pkg::ST_A_USE0;
                  trmb_pkg::CMD_RELEASE: state_in = trmb_pkg::ST_L_USE0;
                  trmb_pkg::CMD_RETIRE:  state_in = trmb_pkg::ST_T_POOL0;
                  trmb_pkg::CMD_CLEAR:   state_in = trmb_pkg::ST_DONE;
               endcase
            end
         end

         // Reserve updates: totals, role holdings, high water
         trmb_pkg::ST_A_USE0: begin
            ctrl.a_sel = trmb_pkg::OPND_USE0;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_USE0;
            state_in   = trmb_pkg::ST_A_HELD0;
         end
         trmb_pkg::ST_A_HELD0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_HELD0_ROLE;
            state_in   = trmb_pkg::ST_A_PEAK0;
         end
         trmb_pkg::ST_A_PEAK0: begin
            ctrl.a_sel = trmb_pkg::OPND_PEAK0;
            ctrl.b_sel = trmb_pkg::OPND_USE0;
            ctrl.dst   = trmb_pkg::DST_PEAK0;
            state_in   = trmb_pkg::ST_A_USE1;
         end
         trmb_pkg::ST_A_USE1: begin
            ctrl.a_sel = trmb_pkg::OPND_USE1;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_USE1;
            state_in   = trmb_pkg::ST_A_HELD1;
         end
         trmb_pkg::ST_A_HELD1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_HELD1_ROLE;
            state_in   = trmb_pkg::ST_A_PEAK1;
         end
         trmb_pkg::ST_A_PEAK1: begin
            ctrl.a_sel = trmb_pkg::OPND_PEAK1;
            ctrl.b_sel = trmb_pkg::OPND_USE1;
            ctrl.dst   = trmb_pkg::DST_PEAK1;
            state_in   = trmb_pkg::ST_DONE;
         end

         // Release updates
         trmb_pkg::ST_L_USE0: begin
            ctrl.a_sel = trmb_pkg::OPND_USE0;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_USE0;
            state_in   = trmb_pkg::ST_L_USE1;
         end
         trmb_pkg::ST_L_USE1: begin
            ctrl.a_sel = trmb_pkg::OPND_USE1;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_USE1;
            state_in   = trmb_pkg::ST_L_HELD0;
         end
         trmb_pkg::ST_L_HELD0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_HELD0_ROLE;
            state_in   = trmb_pkg::ST_L_HELD1;
         end
         trmb_pkg::ST_L_HELD1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_ROLE;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_HELD1_ROLE;
            state_in   = trmb_pkg::ST_DONE;
         end

         // Retire updates: move bytes from pool to retired pool
         trmb_pkg::ST_T_POOL0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_POOL;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.dst   = trmb_pkg::DST_HELD0_POOL;
            state_in   = trmb_pkg::ST_T_RET0;
         end
         trmb_pkg::ST_T_RET0: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD0_RET;
            ctrl.b_sel = trmb_pkg::OPND_AMT0;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_HELD0_RET;
            state_in   = trmb_pkg::ST_T_POOL1;
         end
         trmb_pkg::ST_T_POOL1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_POOL;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.dst   = trmb_pkg::DST_HELD1_POOL;
            state_in   = trmb_pkg::ST_T_RET1;
         end
         trmb_pkg::ST_T_RET1: begin
            ctrl.a_sel = trmb_pkg::OPND_HELD1_RET;
            ctrl.b_sel = trmb_pkg::OPND_AMT1;
            ctrl.sub   = 1'b0;
            ctrl.dst   = trmb_pkg::DST_HELD1_RET;
            state_in   = trmb_pkg::ST_DONE;
         end

         trmb_pkg::ST_REFUSE: begin
            ctrl.refuse = 1'b1;
            state_in    = trmb_pkg::ST_DONE;
         end
         trmb_pkg::ST_CLEAR: begin
            ctrl.clear = 1'b1;
            state_in   = trmb_pkg::ST_DONE;
         end

         // Hold until the output register is free
         trmb_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               state_in      = trmb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = trmb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
